// ===== sv/lafo_pkg.sv =====
// lafo_pkg: shared constants and types for the first-fit offset allocator
`timescale 1ns / 1ps
package lafo_pkg;
  localparam int MAX_BUFFERS = 64;
  localparam int IDX_W = $clog2(MAX_BUFFERS);
  localparam int CNT_W = $clog2(MAX_BUFFERS + 1);
  localparam int TIME_W = 32;
  localparam int SIZE_W = 32;
  localparam int OFF_W = 38;
  localparam int INDEX_OUT_W = 6;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_CLEARED = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_EV,
    S_INS_RD,
    S_INS_EV
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
  } entry_t;
endpackage

// ===== sv/lafo_if.sv =====
// lafo_if: request and result channel interfaces
`timescale 1ns / 1ps
interface lafo_req_if;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [31:0]             start_time;
  logic [31:0]             end_time;
  logic [31:0]             buffer_size;
  modport source (output valid, cmd, start_time, end_time, buffer_size, input ready);
  modport sink (input valid, cmd, start_time, end_time, buffer_size, output ready);
endinterface

interface lafo_res_if;
  logic        valid;
  logic        ready;
  logic [37:0] placed_offset;
  logic [5:0]  item_index;
  logic [1:0]  status;
  modport source (output valid, placed_offset, item_index, status, input ready);
  modport sink (input valid, placed_offset, item_index, status, output ready);
endinterface

// ===== sv/lifetime_aware_first_fit_offset.sv =====
// lifetime_aware_first_fit_offset: first-fit offset allocator for lifetime-scoped buffers
// clear, bad lifetime or full table answer in the cycle after the item is taken
// a placement walks the placed buffers in offset order, a read state and an evaluate state per buffer,
//   then inserts by shifting entries up, all on the single read port of the entry memory
// one item at a time: ready only in idle with the result register empty
// reset: synchronous, clears the placed count, sequencer and result valid; memory is not cleared
`timescale 1ns / 1ps
module lifetime_aware_first_fit_offset (
  input  logic       clk,
  input  logic       rst,
  lafo_req_if.sink   in_ch,
  lafo_res_if.source out_ch
);
  import lafo_pkg::*;

  // entry memory, kept sorted by ascending offset
  entry_t mem [MAX_BUFFERS];
  entry_t rdata;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [OFF_W-1:0] best, best_next;
  logic [TIME_W-1:0] req_s, req_e;
  logic [SIZE_W-1:0] req_size;

  logic              res_valid, res_valid_next;
  logic [OFF_W-1:0]  res_off, res_off_next;
  logic [INDEX_OUT_W-1:0] res_idx, res_idx_next;
  status_t           res_status, res_status_next;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;
  logic             in_fire;

  // compare unit on the entry read back
  logic             overlap, fits;
  logic [OFF_W:0]   top_full;
  logic [OFF_W-1:0] gap;
  entry_t           new_entry;

  assign in_ch.ready = (state == S_IDLE) && !res_valid;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign out_ch.valid = res_valid;
  assign out_ch.placed_offset = res_off;
  assign out_ch.item_index = res_idx;
  assign out_ch.status = res_status;

  assign overlap = (rdata.start_time < req_e) && (req_s < rdata.end_time);
  assign gap = rdata.offset - best;
  assign fits = (rdata.offset >= best) && (gap >= {{(OFF_W-SIZE_W){1'b0}}, req_size});
  assign top_full = {1'b0, rdata.offset} + {{(OFF_W+1-SIZE_W){1'b0}}, rdata.size};
  assign new_entry = '{start_time: req_s, end_time: req_e, offset: best, size: req_size};

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      res_valid <= res_valid_next;
    end
    pos <= pos_next;
    best <= best_next;
    res_off <= res_off_next;
    res_idx <= res_idx_next;
    res_status <= res_status_next;
    if (in_fire) begin
      req_s <= in_ch.start_time;
      req_e <= in_ch.end_time;
      req_size <= in_ch.buffer_size;
    end
  end

  // sequencer: walk in offset order, then sorted insertion by shifting up
  always_comb begin
    state_next = state;
    count_next = count;
    pos_next = pos;
    best_next = best;
    res_valid_next = res_valid && !out_ch.ready;
    res_off_next = res_off;
    res_idx_next = res_idx;
    res_status_next = res_status;
    we = 1'b0;
    waddr = pos[IDX_W-1:0];
    wdata = new_entry;
    raddr = pos[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          best_next = '0;
          pos_next = '0;
          if (in_ch.cmd) begin
            count_next = '0;
            res_valid_next = 1'b1;
            res_off_next = '0;
            res_idx_next = '0;
            res_status_next = ST_CLEARED;
          end else if (in_ch.end_time <= in_ch.start_time) begin
            res_valid_next = 1'b1;
            res_off_next = '0;
            res_idx_next = '0;
            res_status_next = ST_BAD;
          end else if (count == CNT_W'(MAX_BUFFERS)) begin
            res_valid_next = 1'b1;
            res_off_next = '0;
            res_idx_next = '0;
            res_status_next = ST_FULL;
          end else if (count == '0) begin
            state_next = S_INS_RD;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (overlap && fits) begin
          pos_next = count;
          state_next = S_INS_RD;
        end else begin
          if (overlap && (top_full[OFF_W-1:0] > best)) begin
            best_next = top_full[OFF_W-1:0];
          end
          pos_next = pos + 1'b1;
          if (pos + 1'b1 == count) begin
            pos_next = count;
            state_next = S_INS_RD;
          end else begin
            state_next = S_WALK_RD;
          end
        end
      end
      S_INS_RD: begin
        raddr = pos[IDX_W-1:0] - 1'b1;
        if (pos == '0) begin
          we = 1'b1;
          wdata = new_entry;
          res_valid_next = 1'b1;
          res_off_next = best;
          res_idx_next = count[INDEX_OUT_W-1:0];
          res_status_next = ST_PLACED;
          count_next = count + 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_INS_EV;
        end
      end
      S_INS_EV: begin
        we = 1'b1;
        if (rdata.offset > best) begin
          wdata = rdata;
          pos_next = pos - 1'b1;
          state_next = S_INS_RD;
        end else begin
          wdata = new_entry;
          res_valid_next = 1'b1;
          res_off_next = best;
          res_idx_next = count[INDEX_OUT_W-1:0];
          res_status_next = ST_PLACED;
          count_next = count + 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule
